// ===== hw/rtl/clist_pkg.sv =====
// shared types, widths and codes for the circular list engine
// no dependencies; used by clist_pool, clist_ctrl and circular_list_engine
`timescale 1ns / 1ps

package clist_pkg;

	localparam int SLOT_W       = 6;
	localparam int COUNT_W      = 7;
	localparam int DATA_W       = 32;
	localparam int DEF_CAPACITY = 64;

	localparam logic [2:0] OP_INS_HEAD  = 3'd0;
	localparam logic [2:0] OP_INS_TAIL  = 3'd1;
	localparam logic [2:0] OP_INS_AFTER = 3'd2;
	localparam logic [2:0] OP_DEL_HEAD  = 3'd3;
	localparam logic [2:0] OP_DEL_TAIL  = 3'd4;
	localparam logic [2:0] OP_DEL_KEY   = 3'd5;
	localparam logic [2:0] OP_SEARCH    = 3'd6;
	localparam logic [2:0] OP_TRAVERSE  = 3'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [DATA_W-1:0]  word_t;

	typedef struct packed {
		slot_t rd_addr;
		logic  val_we;
		slot_t val_addr;
		word_t val_data;
		logic  nxt_we;
		slot_t nxt_addr;
		slot_t nxt_data;
		logic  prv_we;
		slot_t prv_addr;
		slot_t prv_data;
		slot_t fs_rd_addr;
		logic  fs_we;
		slot_t fs_wr_addr;
		slot_t fs_wr_data;
	} pool_cmd_t;

	typedef struct packed {
		word_t val;
		slot_t nxt;
		slot_t prv;
		slot_t free_slot;
	} pool_rd_t;

endpackage

// ===== hw/rtl/clist_pool.sv =====
// node pool: value, next and prev memories plus the free slot stack
// depends on clist_pkg; driven by clist_ctrl
`timescale 1ns / 1ps

module clist_pool #(
	parameter int CAPACITY = clist_pkg::DEF_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clist_pkg::pool_cmd_t cmd,
	output clist_pkg::pool_rd_t  rd
);
	import clist_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	word_t val_mem [CAPACITY];
	slot_t nxt_mem [CAPACITY];
	slot_t prv_mem [CAPACITY];
	slot_t fs_mem  [CAPACITY];
	logic [CAPACITY-1:0] fs_vld_q;

	word_t val_q;
	slot_t nxt_q;
	slot_t prv_q;
	slot_t free_q;

	logic [IW-1:0] rd_idx;
	logic [IW-1:0] fs_rd_idx;

	assign rd_idx    = cmd.rd_addr[IW-1:0];
	assign fs_rd_idx = cmd.fs_rd_addr[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			val_mem[cmd.val_addr[IW-1:0]] <= cmd.val_data;
		end
		if (cmd.nxt_we) begin
			nxt_mem[cmd.nxt_addr[IW-1:0]] <= cmd.nxt_data;
		end
		if (cmd.prv_we) begin
			prv_mem[cmd.prv_addr[IW-1:0]] <= cmd.prv_data;
		end
		if (cmd.fs_we) begin
			fs_mem[cmd.fs_wr_addr[IW-1:0]] <= cmd.fs_wr_data;
		end
		val_q  <= val_mem[rd_idx];
		nxt_q  <= nxt_mem[rd_idx];
		prv_q  <= prv_mem[rd_idx];
		free_q <= fs_vld_q[fs_rd_idx] ? fs_mem[fs_rd_idx] : SLOT_W'(fs_rd_idx);
	end

	// unwritten stack entries read as their own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_vld_q <= '0;
		end else if (cmd.fs_we) begin
			fs_vld_q[cmd.fs_wr_addr[IW-1:0]] <= 1'b1;
		end
	end

	assign rd.val       = val_q;
	assign rd.nxt       = nxt_q;
	assign rd.prv       = prv_q;
	assign rd.free_slot = free_q;

endmodule

// ===== hw/rtl/clist_ctrl.sv =====
// sequencer: walks the list one node per cycle with a single key comparator
// depends on clist_pkg; issues commands to clist_pool
`timescale 1ns / 1ps

module clist_ctrl #(
	parameter int CAPACITY = clist_pkg::DEF_CAPACITY
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [2:0]                  op,
	input  logic signed [31:0]          key,
	input  logic signed [31:0]          value,
	output logic                        busy,
	output clist_pkg::pool_cmd_t        cmd,
	input  clist_pkg::pool_rd_t         rd,
	output logic                        valid,
	output logic [1:0]                  status,
	output logic signed [31:0]          data_out,
	output logic                        last
);
	import clist_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TAIL   = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_FIND   = 3'd3;
	localparam logic [2:0] S_LINK1  = 3'd4;
	localparam logic [2:0] S_LINK2  = 3'd5;
	localparam logic [2:0] S_UNLINK = 3'd6;
	localparam logic [2:0] S_TRAV   = 3'd7;

	logic [2:0]  state_q;
	logic [2:0]  op_q;
	word_t       key_q;
	word_t       value_q;
	slot_t       head_q;
	count_t      count_q;
	slot_t       cur_q;
	count_t      step_q;
	slot_t       a_q;
	slot_t       p_q;
	slot_t       n_q;
	word_t       v_q;
	logic        valid_q;
	logic [1:0]  status_q;
	word_t       data_q;
	logic        last_q;

	logic   empty;
	logic   full;
	logic   match;
	logic   walk_end;
	count_t step_inc;
	count_t count_dec;
	slot_t  t_slot;

	assign empty     = (count_q == '0);
	assign full      = (count_q == COUNT_W'(CAPACITY));
	assign match     = (rd.val == key_q);
	assign step_inc  = step_q + COUNT_W'(1);
	assign count_dec = count_q - COUNT_W'(1);
	assign walk_end  = (step_inc == count_q);
	assign t_slot    = rd.free_slot;
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.rd_addr    = head_q;
		cmd.fs_rd_addr = count_q[SLOT_W-1:0];
		cmd.fs_wr_addr = count_dec[SLOT_W-1:0];
		cmd.fs_wr_data = a_q;
		case (state_q)
			S_TAIL: begin
				cmd.rd_addr = rd.prv;
			end
			S_FIND, S_TRAV: begin
				cmd.rd_addr = rd.nxt;
			end
			S_LINK1: begin
				cmd.val_we   = 1'b1;
				cmd.val_addr = t_slot;
				cmd.val_data = value_q;
				cmd.nxt_we   = 1'b1;
				cmd.nxt_addr = t_slot;
				cmd.nxt_data = empty ? t_slot : n_q;
				cmd.prv_we   = 1'b1;
				cmd.prv_addr = t_slot;
				cmd.prv_data = empty ? t_slot : a_q;
			end
			S_LINK2: begin
				cmd.prv_we   = 1'b1;
				cmd.prv_addr = n_q;
				cmd.prv_data = t_slot;
				cmd.nxt_we   = 1'b1;
				cmd.nxt_addr = a_q;
				cmd.nxt_data = t_slot;
			end
			S_UNLINK: begin
				cmd.fs_we = 1'b1;
				if (count_q > COUNT_W'(1)) begin
					cmd.nxt_we   = 1'b1;
					cmd.nxt_addr = p_q;
					cmd.nxt_data = n_q;
					cmd.prv_we   = 1'b1;
					cmd.prv_addr = n_q;
					cmd.prv_data = p_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op)
							OP_INS_HEAD, OP_INS_TAIL: begin
								if (full) begin
									valid_q <= 1'b1;
								end else if (empty) begin
									state_q <= S_LINK1;
								end else begin
									state_q <= S_TAIL;
								end
							end
							OP_DEL_HEAD: begin
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									state_q <= S_FETCH;
								end
							end
							OP_DEL_TAIL: begin
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									state_q <= S_TAIL;
								end
							end
							OP_TRAVERSE: begin
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									state_q <= S_TRAV;
								end
							end
							default: begin
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									state_q <= S_FIND;
								end
							end
						endcase
					end
				end
				S_TAIL: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= (op_q == OP_INS_HEAD || op_q == OP_INS_TAIL) ? S_LINK1 : S_UNLINK;
				end
				S_FIND: begin
					if (match) begin
						if (op_q == OP_INS_AFTER) begin
							if (full) begin
								valid_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_LINK1;
							end
						end else if (op_q == OP_DEL_KEY) begin
							state_q <= S_UNLINK;
						end else begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (walk_end) begin
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LINK1: begin
					if (empty) begin
						head_q  <= t_slot;
						count_q <= COUNT_W'(1);
						valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LINK2;
					end
				end
				S_LINK2: begin
					if (op_q == OP_INS_HEAD) begin
						head_q <= t_slot;
					end
					count_q <= count_q + COUNT_W'(1);
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_UNLINK: begin
					if (count_q <= COUNT_W'(1)) begin
						head_q <= '0;
					end else if (a_q == head_q) begin
						head_q <= n_q;
					end
					count_q <= count_dec;
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_TRAV: begin
					valid_q <= 1'b1;
					if (walk_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operands, walk pointers and result word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= op;
				key_q    <= key;
				value_q  <= value;
				cur_q    <= head_q;
				a_q      <= head_q;
				step_q   <= '0;
				data_q   <= '0;
				last_q   <= 1'b1;
				status_q <= full ? ST_FULL : ST_EMPTY;
			end
			S_TAIL: begin
				a_q <= rd.prv;
			end
			S_FETCH: begin
				p_q <= rd.prv;
				n_q <= rd.nxt;
				v_q <= rd.val;
			end
			S_FIND: begin
				data_q <= '0;
				last_q <= 1'b1;
				if (match) begin
					a_q      <= cur_q;
					p_q      <= rd.prv;
					n_q      <= rd.nxt;
					v_q      <= rd.val;
					status_q <= (op_q == OP_INS_AFTER && full) ? ST_FULL : ST_OK;
				end else begin
					cur_q    <= rd.nxt;
					step_q   <= step_inc;
					status_q <= ST_NOT_FOUND;
				end
			end
			S_LINK1, S_LINK2: begin
				status_q <= ST_OK;
				data_q   <= '0;
				last_q   <= 1'b1;
			end
			S_UNLINK: begin
				status_q <= ST_OK;
				data_q   <= v_q;
				last_q   <= 1'b1;
			end
			S_TRAV: begin
				status_q <= ST_OK;
				data_q   <= rd.val;
				last_q   <= walk_end;
				step_q   <= step_inc;
			end
			default: begin
			end
		endcase
	end

	assign valid    = valid_q;
	assign status   = status_q;
	assign data_out = data_q;
	assign last     = last_q;

endmodule

// ===== hw/rtl/circular_list_engine.sv =====
// circular doubly linked list engine over a pool of CAPACITY nodes
// empty-list answers and pool-full answers to head/tail inserts are given straight from idle;
// search, delete-by-key and insert-after walk from the head first; traverse one word per cycle
// one op at a time; busy stays high until the last word, set by the node-per-cycle list walk
// reset empties the list at once, no clearing pass; the receiver cannot stall results
`timescale 1ns / 1ps

module circular_list_engine #(
	parameter int CAPACITY = clist_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] key,
	input  logic signed [31:0] value,
	output logic               valid,
	output logic [1:0]         status,
	output logic signed [31:0] data_out,
	output logic               last
);
	import clist_pkg::*;

	pool_cmd_t cmd;
	pool_rd_t  rd;

	clist_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.op      (op),
		.key     (key),
		.value   (value),
		.busy    (busy),
		.cmd     (cmd),
		.rd      (rd),
		.valid   (valid),
		.status  (status),
		.data_out(data_out),
		.last    (last)
	);

	clist_pool #(
		.CAPACITY(CAPACITY)
	) u_pool (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rd    (rd)
	);

	a_valid_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy || start))
		else $error("result word without an op in progress");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	a_more_words: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("non-final word but engine idle");

	a_error_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status != ST_OK) |-> (data_out == '0))
		else $error("error status with nonzero data");

endmodule
